FILE: hdl/htsm_pkg.sv
// Shared types, constants and helper functions for the two-wire sensor master.
package htsm_pkg;

	// Phase codes of the sequencer.
	localparam int PHASE_W = 4;
	localparam logic [PHASE_W-1:0] PH_BURST = 4'd0;
	localparam logic [PHASE_W-1:0] PH_START = 4'd1;
	localparam logic [PHASE_W-1:0] PH_CMD   = 4'd2;
	localparam logic [PHASE_W-1:0] PH_IDLE  = 4'd3;
	localparam logic [PHASE_W-1:0] PH_WAIT  = 4'd4;
	localparam logic [PHASE_W-1:0] PH_RDHI  = 4'd5;
	localparam logic [PHASE_W-1:0] PH_ACK   = 4'd6;
	localparam logic [PHASE_W-1:0] PH_RDLO  = 4'd7;
	localparam logic [PHASE_W-1:0] PH_NOACK = 4'd8;
	localparam logic [PHASE_W-1:0] PH_REPHI = 4'd9;
	localparam logic [PHASE_W-1:0] PH_GAP   = 4'd10;
	localparam logic [PHASE_W-1:0] PH_REPLO = 4'd11;

	// Sensor commands and burst length.
	localparam logic [3:0] BURST_CLOCKS = 4'd10;
	localparam logic [7:0] CMD_RESET    = 8'h1E;
	localparam logic [7:0] CMD_TEMP     = 8'h03;
	localparam logic [7:0] CMD_HUMID    = 8'h05;

	// Report identifiers.
	localparam logic [4:0] ID_HUM_HI  = 5'h12;
	localparam logic [4:0] ID_HUM_LO  = 5'h13;
	localparam logic [4:0] ID_TEMP_HI = 5'h14;
	localparam logic [4:0] ID_TEMP_LO = 5'h15;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_READY_WAIT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_READY_POLL    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POLL_LIMIT    = 2'd3;

	typedef struct packed {
		logic [31:0] poll_interval;
		logic [15:0] ready_wait_ticks;
		logic [15:0] ready_poll_ticks;
		logic [7:0]  ready_poll_limit;
	} htsm_cfg_t;

	localparam htsm_cfg_t CFG_RESET = '{
		poll_interval:    32'd20000,
		ready_wait_ticks: 16'd1000,
		ready_poll_ticks: 16'd200,
		ready_poll_limit: 8'd100
	};

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [15:0]        delay_count;
		logic [3:0]         bit_count;
		logic [7:0]         command_shift;
		logic [15:0]        read_shift;
		logic [7:0]         ready_polls;
		logic [31:0]        elapsed_ticks;
		logic               next_is_humidity;
	} htsm_state_t;

	localparam htsm_state_t STATE_RESET = '{
		phase:            PH_BURST,
		delay_count:      16'd0,
		bit_count:        4'd0,
		command_shift:    8'd0,
		read_shift:       16'd0,
		ready_polls:      8'd0,
		elapsed_ticks:    32'd0,
		next_is_humidity: 1'b0
	};

	typedef struct packed {
		logic       clock_level;
		logic       data_release;
		logic       packet_valid;
		logic [4:0] packet_id;
		logic [7:0] packet_byte;
	} htsm_result_t;

	// Clock level for each step of the start sequence.
	function automatic logic start_clk(input logic [2:0] s);
		logic v;
		unique case (s)
			3'd0, 3'd1, 3'd3, 3'd4: v = 1'b1;
			default:                v = 1'b0;
		endcase
		return v;
	endfunction

	// Data level for each step of the start sequence.
	function automatic logic start_dat(input logic [2:0] s);
		logic v;
		unique case (s)
			3'd0, 3'd4, 3'd5: v = 1'b1;
			default:          v = 1'b0;
		endcase
		return v;
	endfunction

endpackage

FILE: hdl/htsm_step.sv
// Single-tick next-state and pin/report logic of the sensor sequencer.
module htsm_step
	import htsm_pkg::*;
(
	input  htsm_state_t  cur,
	input  htsm_cfg_t    cfg,
	input  logic         data_pin,
	output htsm_state_t  nxt,
	output htsm_result_t res
);

	logic [2:0] start_idx;
	logic [3:0] bit_inc;
	logic [31:0] elapsed_mid;

	assign start_idx = (cur.delay_count < 16'd6) ? cur.delay_count[2:0] : 3'd5;
	assign bit_inc   = cur.bit_count + 4'd1;

	// One sequencer step per tick.
	always_comb begin
		nxt         = cur;
		elapsed_mid = cur.elapsed_ticks;
		res         = '{clock_level: 1'b0, data_release: 1'b1, packet_valid: 1'b0,
			packet_id: 5'd0, packet_byte: 8'd0};

		unique case (cur.phase)
			PH_BURST: begin
				if (!cur.delay_count[0]) begin
					res.clock_level = 1'b1;
					nxt.delay_count = 16'd1;
				end else begin
					nxt.delay_count = 16'd0;
					nxt.bit_count   = bit_inc;
					if (bit_inc >= BURST_CLOCKS) begin
						nxt.phase         = PH_START;
						nxt.bit_count     = 4'd0;
						nxt.command_shift = CMD_RESET;
					end
				end
			end
			PH_START: begin
				res.clock_level  = start_clk(start_idx);
				res.data_release = start_dat(start_idx);
				if (start_idx >= 3'd5) begin
					nxt.phase       = PH_CMD;
					nxt.delay_count = 16'd0;
					nxt.bit_count   = 4'd0;
				end else begin
					nxt.delay_count = {13'd0, start_idx + 3'd1};
				end
			end
			PH_CMD: begin
				if (!cur.bit_count[3]) begin
					// Command bits go out most significant first.
					res.data_release = cur.command_shift[3'd7 - cur.bit_count[2:0]];
					if (!cur.delay_count[0]) begin
						nxt.delay_count = 16'd1;
					end else begin
						res.clock_level = 1'b1;
						nxt.delay_count = 16'd0;
						nxt.bit_count   = bit_inc;
					end
				end else begin
					// Acknowledge clock; the sensor's answer is not looked at.
					if (cur.delay_count == 16'd1) begin
						res.clock_level = 1'b1;
					end
					if (cur.delay_count >= 16'd2) begin
						nxt.delay_count = 16'd0;
						nxt.bit_count   = 4'd0;
						if (cur.command_shift == CMD_RESET) begin
							nxt.phase = PH_IDLE;
						end else begin
							nxt.phase       = PH_WAIT;
							nxt.delay_count = cfg.ready_wait_ticks;
							nxt.ready_polls = 8'd0;
						end
					end else begin
						nxt.delay_count = cur.delay_count + 16'd1;
					end
				end
			end
			PH_IDLE: begin
				if (cur.elapsed_ticks > cfg.poll_interval) begin
					elapsed_mid          = 32'd0;
					nxt.command_shift    = cur.next_is_humidity ? CMD_HUMID : CMD_TEMP;
					nxt.next_is_humidity = !cur.next_is_humidity;
					nxt.phase            = PH_START;
					nxt.delay_count      = 16'd0;
				end
			end
			PH_WAIT: begin
				if (cur.delay_count != 16'd0) begin
					nxt.delay_count = cur.delay_count - 16'd1;
				end else if (cur.ready_polls >= cfg.ready_poll_limit || !data_pin) begin
					nxt.phase       = PH_RDHI;
					nxt.read_shift  = 16'd0;
					nxt.bit_count   = 4'd0;
					nxt.delay_count = 16'd0;
				end else begin
					nxt.ready_polls = cur.ready_polls + 8'd1;
					nxt.delay_count = cfg.ready_poll_ticks;
				end
			end
			PH_RDHI, PH_RDLO: begin
				// Bits are sampled on the clock-high tick.
				if (!cur.delay_count[0]) begin
					res.clock_level = 1'b1;
					nxt.read_shift  = {cur.read_shift[14:0], data_pin};
					nxt.delay_count = 16'd1;
				end else begin
					nxt.delay_count = 16'd0;
					nxt.bit_count   = bit_inc;
					if (bit_inc >= 4'd8) begin
						nxt.phase     = (cur.phase == PH_RDHI) ? PH_ACK : PH_NOACK;
						nxt.bit_count = 4'd0;
					end
				end
			end
			PH_ACK: begin
				if (cur.delay_count == 16'd1) begin
					res.data_release = 1'b0;
				end
				if (cur.delay_count == 16'd2) begin
					res.data_release = 1'b0;
					res.clock_level  = 1'b1;
				end
				if (cur.delay_count >= 16'd3) begin
					nxt.phase       = PH_RDLO;
					nxt.delay_count = 16'd0;
					nxt.bit_count   = 4'd0;
				end else begin
					nxt.delay_count = cur.delay_count + 16'd1;
				end
			end
			PH_NOACK: begin
				if (cur.delay_count == 16'd0) begin
					res.clock_level = 1'b1;
					nxt.delay_count = 16'd1;
				end else begin
					nxt.delay_count = 16'd0;
					nxt.phase       = PH_REPHI;
				end
			end
			PH_REPHI: begin
				res.packet_valid = 1'b1;
				res.packet_id    = cur.next_is_humidity ? ID_TEMP_HI : ID_HUM_HI;
				res.packet_byte  = cur.read_shift[15:8];
				nxt.phase        = PH_GAP;
			end
			PH_GAP: begin
				nxt.phase = PH_REPLO;
			end
			PH_REPLO: begin
				res.packet_valid = 1'b1;
				res.packet_id    = cur.next_is_humidity ? ID_TEMP_LO : ID_HUM_LO;
				res.packet_byte  = cur.read_shift[7:0];
				nxt.phase        = PH_IDLE;
			end
			default: begin
				nxt.phase       = PH_IDLE;
				nxt.delay_count = 16'd0;
				nxt.bit_count   = 4'd0;
			end
		endcase

		// Tick counter, cleared when a poll starts and saturating at its maximum.
		nxt.elapsed_ticks = (elapsed_mid != 32'hFFFF_FFFF) ? elapsed_mid + 32'd1 : elapsed_mid;
	end

endmodule

FILE: hdl/humidity_temp_sensor_two_wire_master.sv
// Top level of the two-wire humidity and temperature sensor master.
// Each accepted tick beat yields one result beat, registered in the cycle after acceptance.
// Throughput is one tick per cycle unless out_ready holds the output: the whole sequencer step is one pass of logic
// between the state register and the result register.
// The output register frees on the cycle its beat is taken, so input is not held off then.
// Reset clears the sequencer to the clock burst and loads the register defaults.
module humidity_temp_sensor_two_wire_master
	import htsm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 data_pin,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 clock_level,
	output logic                 data_release,
	output logic                 packet_valid,
	output logic [4:0]           packet_id,
	output logic [7:0]           packet_byte,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	htsm_cfg_t    cfg_q;
	htsm_state_t  state_q;
	htsm_state_t  state_next;
	htsm_result_t res_next;
	htsm_result_t res_q;
	logic         out_valid_q;
	logic         in_fire;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_POLL_INTERVAL: cfg_q.poll_interval    <= cfg_data;
				REG_READY_WAIT:    cfg_q.ready_wait_ticks <= cfg_data[15:0];
				REG_READY_POLL:    cfg_q.ready_poll_ticks <= cfg_data[15:0];
				REG_POLL_LIMIT:    cfg_q.ready_poll_limit <= cfg_data[7:0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	// Sequencer step.
	htsm_step u_step (
		.cur      (state_q),
		.cfg      (cfg_q),
		.data_pin (data_pin),
		.nxt      (state_next),
		.res      (res_next)
	);

	// Sequencer state advances once per accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (in_fire) begin
			state_q <= state_next;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= res_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign clock_level  = res_q.clock_level;
	assign data_release = res_q.data_release;
	assign packet_valid = res_q.packet_valid;
	assign packet_id    = res_q.packet_id;
	assign packet_byte  = res_q.packet_byte;

`ifndef SYNTH
	// Every accepted tick produces a result beat on the next cycle.
	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_valid)
		else $error("accepted tick did not produce a result beat");

	// A report carries one of the four measurement identifiers.
	a_report_id: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && packet_valid) |-> (packet_id == ID_HUM_HI || packet_id == ID_HUM_LO
			|| packet_id == ID_TEMP_HI || packet_id == ID_TEMP_LO))
		else $error("report beat with unknown identifier");

	// Without a report the identifier and byte are zero.
	a_no_report_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !packet_valid) |-> (packet_id == 5'd0 && packet_byte == 8'd0))
		else $error("report fields set without a report");

	// Wait and idle ticks hold the clock low with data released.
	a_wait_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (state_q.phase == PH_WAIT || state_q.phase == PH_IDLE))
			|=> (!clock_level && data_release))
		else $error("bus driven during a wait or idle tick");
`endif

endmodule
